/* src/rkrt_pkg.sv */
// ----------------------------------------------------------------------------
// rkrt_pkg
// Shared types and codes for the root key ring table: request, result and
// stored record layouts, mode and lifecycle codes.
// ----------------------------------------------------------------------------
package rkrt_pkg;

    localparam int MAX_KEYS_DEF = 8;
    localparam logic [3:0] CAP_RESET = 4'd8;

    localparam logic [2:0] MODE_FIND   = 3'd0;
    localparam logic [2:0] MODE_UPSERT = 3'd1;
    localparam logic [2:0] MODE_ROTATE = 3'd2;
    localparam logic [2:0] MODE_RETIRE = 3'd3;
    localparam logic [2:0] MODE_REVOKE = 3'd4;
    // codes with no operation behind them
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam logic [1:0] LIFE_ACTIVE  = 2'd0;
    localparam logic [1:0] LIFE_RETIRED = 2'd1;
    localparam logic [1:0] LIFE_REVOKED = 2'd2;
    // neither active nor revoked, stored as given
    localparam logic [1:0] LIFE_OTHER   = 2'd3;

    // stored record, one memory word per slot
    typedef struct packed {
        logic [1:0]  life;
        logic [63:0] not_after;
        logic [63:0] not_before;
        logic [3:0]  roles;
        logic [31:0] epoch;
        logic [31:0] id;
    } rec_t;

    // input item, key_id in the lowest bits
    typedef struct packed {
        logic        key_material_ok;
        logic [1:0]  rec_lifecycle;
        logic [63:0] valid_until;
        logic [63:0] valid_from;
        logic [3:0]  role_mask;
        logic [31:0] rec_epoch;
        logic [31:0] rec_key_id;
        logic [31:0] epoch;
        logic [31:0] key_id;
    } req_t;

    // result item, ok in the lowest bit
    typedef struct packed {
        logic [63:0] out_valid_until;
        logic [63:0] out_valid_from;
        logic [3:0]  out_role_mask;
        logic [1:0]  out_lifecycle;
        logic        erase_key;
        logic        store_key;
        logic [2:0]  slot;
        logic        ok;
    } res_t;

    localparam int REQ_W = $bits(req_t);
    localparam int RES_W = $bits(res_t);
    localparam int IN_TDATA_W = ((REQ_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

/* src/rkrt_ram.sv */
// ----------------------------------------------------------------------------
// rkrt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rkrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/root_key_ring_table.sv */
// ----------------------------------------------------------------------------
// root_key_ring_table
// Table of root-key records keyed by (key id, epoch): find, upsert, rotate,
// retire and revoke, with store and erase flags for an outside key store.
// Each item runs a linear scan over the record memory, one slot read per
// cycle below the entry count, then a decide state that sets the result and
// any write, a retire state for rotate only, and a push to the output. The next
// item is taken after the push, even if a result waits; its result then holds.
// Reset: entry count cleared, capacity limit 8; the record memory keeps no
// reset value and only slots below the count are ever read.
// ----------------------------------------------------------------------------
module root_key_ring_table #(
    parameter int MAX_KEYS = rkrt_pkg::MAX_KEYS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [3:0]                         cfg_wdata,     // capacity_limit
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // key_id, epoch, rec_key_id, rec_epoch, role_mask, valid_from,
    // valid_until, rec_lifecycle, key_material_ok, zero pad
    input  logic [rkrt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [2:0]                         s_axis_tuser,  // mode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // ok, slot, store_key, erase_key, out_lifecycle, out_role_mask,
    // out_valid_from, out_valid_until, zero pad
    output logic [rkrt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    import rkrt_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_RETIRE = 3'd3;
    localparam logic [2:0] ST_PUSH   = 3'd4;

    logic [2:0]    state_reg, state_next;
    req_t          req_reg, req_next;
    logic [2:0]    mode_reg, mode_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          cmp_v_reg, cmp_v_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          hit_a_reg, hit_a_next;
    logic [AW-1:0] slot_a_reg, slot_a_next;
    rec_t          rec_a_reg, rec_a_next;
    logic          hit_b_reg, hit_b_next;
    logic [AW-1:0] slot_b_reg, slot_b_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    cap_reg, cap_next;
    res_t          res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg, out_next;

    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    rec_t          ram_rd_data;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    rec_t          ram_wr_data;

    logic          rec_ok;
    logic          can_append;
    logic          up_ok;
    logic [AW-1:0] up_slot;
    logic          rot_ok;
    rec_t          new_rec;
    logic [AW+2:0] slot_a_ext;
    logic [AW+2:0] up_slot_ext;

    rkrt_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (MAX_KEYS)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_reg};

    // decision terms, used once the scan is done
    always_comb
    begin
        rec_ok = (req_reg.rec_key_id != '0) && (req_reg.rec_epoch != '0)
                 && (req_reg.role_mask != '0)
                 && (req_reg.valid_until > req_reg.valid_from)
                 && req_reg.key_material_ok;
        can_append = (CMPW'(count_reg) < CMPW'(cap_reg)) && (count_reg < CW'(MAX_KEYS));
        up_ok   = rec_ok && (hit_b_reg || can_append);
        up_slot = hit_b_reg ? slot_b_reg : count_reg[AW-1:0];
        rot_ok  = hit_a_reg && (rec_a_reg.life == LIFE_ACTIVE)
                  && (req_reg.rec_key_id == req_reg.key_id)
                  && (req_reg.rec_epoch > req_reg.epoch)
                  && (req_reg.rec_lifecycle == LIFE_ACTIVE) && up_ok;
        new_rec.life       = req_reg.rec_lifecycle;
        new_rec.not_after  = req_reg.valid_until;
        new_rec.not_before = req_reg.valid_from;
        new_rec.roles      = req_reg.role_mask;
        new_rec.epoch      = req_reg.rec_epoch;
        new_rec.id         = req_reg.rec_key_id;
        slot_a_ext  = {3'b000, slot_a_reg};
        up_slot_ext = {3'b000, up_slot};
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        mode_next      = mode_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_v_next     = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_a_next     = hit_a_reg;
        slot_a_next    = slot_a_reg;
        rec_a_next     = rec_a_reg;
        hit_b_next     = hit_b_reg;
        slot_b_next    = slot_b_reg;
        count_next     = count_reg;
        cap_next       = cfg_we ? cfg_wdata : cap_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_idx_reg[AW-1:0];
        ram_wr_en      = 1'b0;
        ram_wr_addr    = up_slot;
        ram_wr_data    = new_rec;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // compare stage of the scan: first match for the addressed key (a)
        // and for the supplied record key (b)
        if (cmp_v_reg)
        begin
            if (!hit_a_reg && (ram_rd_data.id == req_reg.key_id)
                && (ram_rd_data.epoch == req_reg.epoch))
            begin
                hit_a_next  = 1'b1;
                slot_a_next = cmp_idx_reg;
                rec_a_next  = ram_rd_data;
            end
            if (!hit_b_reg && (ram_rd_data.id == req_reg.rec_key_id)
                && (ram_rd_data.epoch == req_reg.rec_epoch))
            begin
                hit_b_next  = 1'b1;
                slot_b_next = cmp_idx_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next      = req_t'(s_axis_tdata[REQ_W-1:0]);
                    mode_next     = s_axis_tuser;
                    scan_idx_next = '0;
                    hit_a_next    = 1'b0;
                    hit_b_next    = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg != count_reg)
                begin
                    ram_rd_en     = 1'b1;
                    cmp_v_next    = 1'b1;
                    cmp_idx_next  = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_next   = '0;
                state_next = ST_PUSH;
                unique case (mode_reg)
                    MODE_FIND:
                    begin
                        if (hit_a_reg)
                        begin
                            res_next.ok              = 1'b1;
                            res_next.slot            = slot_a_ext[2:0];
                            res_next.out_lifecycle   = rec_a_reg.life;
                            res_next.out_role_mask   = rec_a_reg.roles;
                            res_next.out_valid_from  = rec_a_reg.not_before;
                            res_next.out_valid_until = rec_a_reg.not_after;
                        end
                    end
                    MODE_UPSERT:
                    begin
                        if (up_ok)
                        begin
                            ram_wr_en = 1'b1;
                            if (!hit_b_reg)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            res_next.ok        = 1'b1;
                            res_next.slot      = up_slot_ext[2:0];
                            res_next.store_key = (req_reg.rec_lifecycle != LIFE_REVOKED);
                            res_next.erase_key = (req_reg.rec_lifecycle == LIFE_REVOKED);
                        end
                    end
                    MODE_ROTATE:
                    begin
                        if (rot_ok)
                        begin
                            ram_wr_en = 1'b1;
                            if (!hit_b_reg)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            res_next.ok        = 1'b1;
                            res_next.slot      = up_slot_ext[2:0];
                            res_next.store_key = 1'b1;
                            state_next         = ST_RETIRE;
                        end
                    end
                    MODE_RETIRE:
                    begin
                        if (hit_a_reg && (rec_a_reg.life != LIFE_REVOKED))
                        begin
                            ram_wr_en        = 1'b1;
                            ram_wr_addr      = slot_a_reg;
                            ram_wr_data      = rec_a_reg;
                            ram_wr_data.life = LIFE_RETIRED;
                            res_next.ok      = 1'b1;
                            res_next.slot    = slot_a_ext[2:0];
                        end
                    end
                    MODE_REVOKE:
                    begin
                        if (hit_a_reg)
                        begin
                            ram_wr_en          = 1'b1;
                            ram_wr_addr        = slot_a_reg;
                            ram_wr_data        = rec_a_reg;
                            ram_wr_data.life   = LIFE_REVOKED;
                            res_next.ok        = 1'b1;
                            res_next.slot      = slot_a_ext[2:0];
                            res_next.erase_key = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            ST_RETIRE:
            begin
                // current entry of a rotate, distinct from the replacement slot
                ram_wr_en        = 1'b1;
                ram_wr_addr      = slot_a_reg;
                ram_wr_data      = rec_a_reg;
                ram_wr_data.life = LIFE_RETIRED;
                state_next       = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_v_reg     <= 1'b0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
            hit_a_reg     <= 1'b0;
            hit_b_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_v_reg     <= cmp_v_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            hit_a_reg     <= hit_a_next;
            hit_b_reg     <= hit_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        mode_reg     <= mode_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        slot_a_reg   <= slot_a_next;
        rec_a_reg    <= rec_a_next;
        slot_b_reg   <= slot_b_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule

/* test/rkrt_table_checker.sv */
// ----------------------------------------------------------------------------
// rkrt_table_checker
// Watches the request and result streams of the root key ring table. It keeps
// its own copy of the key records and the capacity limit, works out the
// result of every request transfer and compares each result transfer with
// the oldest result still awaited.
// ----------------------------------------------------------------------------
module rkrt_table_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [3:0]                         cfg_wdata,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [rkrt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [2:0]                         s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [rkrt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output int                                 fail_count,
    output int                                 awaiting
);
    import rkrt_pkg::*;

    localparam int SLOTS = MAX_KEYS_DEF;

    rec_t        key_records [SLOTS];
    int unsigned record_count;
    logic [3:0]  cap_limit;
    res_t        awaited_results [$];

    function automatic int find_slot(logic [31:0] id, logic [31:0] ep);
        for (int i = 0; i < SLOTS; i++)
            if (i < record_count && key_records[i].id == id && key_records[i].epoch == ep)
                return i;
        return -1;
    endfunction

    // validates the supplied record, then overwrites a match or appends
    function automatic int store_record(req_t rq);
        int          s;
        int unsigned room;
        if (rq.rec_key_id == 0 || rq.rec_epoch == 0 || rq.role_mask == 0 ||
            rq.valid_until <= rq.valid_from || !rq.key_material_ok)
            return -1;
        s = find_slot(rq.rec_key_id, rq.rec_epoch);
        if (s < 0)
        begin
            room = (cap_limit < SLOTS) ? cap_limit : SLOTS;
            if (record_count >= room)
                return -1;
            s = record_count;
            record_count++;
        end
        key_records[s].id         = rq.rec_key_id;
        key_records[s].epoch      = rq.rec_epoch;
        key_records[s].roles      = rq.role_mask;
        key_records[s].not_before = rq.valid_from;
        key_records[s].not_after  = rq.valid_until;
        key_records[s].life       = rq.rec_lifecycle;
        return s;
    endfunction

    function automatic res_t predict_result(logic [2:0] mode, req_t rq);
        res_t r;
        int   s;
        int   c;
        r = '0;
        case (mode)
            MODE_FIND:
            begin
                s = find_slot(rq.key_id, rq.epoch);
                if (s >= 0)
                begin
                    r.ok              = 1'b1;
                    r.slot            = s[2:0];
                    r.out_lifecycle   = key_records[s].life;
                    r.out_role_mask   = key_records[s].roles;
                    r.out_valid_from  = key_records[s].not_before;
                    r.out_valid_until = key_records[s].not_after;
                end
            end
            MODE_UPSERT:
            begin
                s = store_record(rq);
                if (s >= 0)
                begin
                    r.ok        = 1'b1;
                    r.slot      = s[2:0];
                    r.store_key = (rq.rec_lifecycle != LIFE_REVOKED);
                    r.erase_key = (rq.rec_lifecycle == LIFE_REVOKED);
                end
            end
            MODE_ROTATE:
            begin
                c = find_slot(rq.key_id, rq.epoch);
                // replacement key differs from current, so the current slot stays put
                if (c >= 0 && key_records[c].life == LIFE_ACTIVE &&
                    rq.rec_key_id == rq.key_id && rq.rec_epoch > rq.epoch &&
                    rq.rec_lifecycle == LIFE_ACTIVE)
                begin
                    s = store_record(rq);
                    if (s >= 0)
                    begin
                        key_records[c].life = LIFE_RETIRED;
                        r.ok        = 1'b1;
                        r.slot      = s[2:0];
                        r.store_key = 1'b1;
                    end
                end
            end
            MODE_RETIRE:
            begin
                s = find_slot(rq.key_id, rq.epoch);
                if (s >= 0 && key_records[s].life != LIFE_REVOKED)
                begin
                    key_records[s].life = LIFE_RETIRED;
                    r.ok   = 1'b1;
                    r.slot = s[2:0];
                end
            end
            MODE_REVOKE:
            begin
                s = find_slot(rq.key_id, rq.epoch);
                if (s >= 0)
                begin
                    key_records[s].life = LIFE_REVOKED;
                    r.ok        = 1'b1;
                    r.slot      = s[2:0];
                    r.erase_key = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(res_t got);
        res_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: result with none awaited, expected none actual %h", $time, got);
            fail_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            compare_field("ok", want.ok, got.ok);
            compare_field("slot", want.slot, got.slot);
            compare_field("store_key", want.store_key, got.store_key);
            compare_field("erase_key", want.erase_key, got.erase_key);
            compare_field("out_lifecycle", want.out_lifecycle, got.out_lifecycle);
            compare_field("out_role_mask", want.out_role_mask, got.out_role_mask);
            compare_field("out_valid_from", want.out_valid_from, got.out_valid_from);
            compare_field("out_valid_until", want.out_valid_until, got.out_valid_until);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_count = 0;
            cap_limit    = CAP_RESET;
            awaited_results.delete();
            fail_count   = 0;
            awaiting    <= 0;
        end
        else
        begin
            // results first, so a result never meets the request of this same edge
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata[RES_W-1:0]);
            if (cfg_we)
                cap_limit = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.insert(awaited_results.size(),
                                       predict_result(s_axis_tuser,
                                                      s_axis_tdata[REQ_W-1:0]));
            awaiting <= awaited_results.size();
        end
    end

endmodule

/* test/root_key_ring_table_tb.sv */
// ----------------------------------------------------------------------------
// root_key_ring_table_tb
// Drives the root key ring table with a directed set of lookups, record
// checks, rotations, retires and revokes, then with random requests over a
// small key space under several capacity limits, while both stream sides
// idle at random. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module root_key_ring_table_tb;
    import rkrt_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 300;
    localparam int SETTLE       = 16;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [3:0]             cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [2:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int awaiting;
    int cycle_count = 0;
    bit quiet = 1'b0;

    root_key_ring_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rkrt_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .awaiting      (awaiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // small id and epoch space so that lookups hit often
    function automatic logic [31:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return $urandom_range(1, 3);
        return (r == 8) ? 32'hFFFF_FFFF : $urandom;
    endfunction

    function automatic logic [31:0] pick_epoch();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return $urandom_range(1, 5);
        return (r == 8) ? 32'hFFFF_FFFF : $urandom;
    endfunction

    task automatic send_item(logic [2:0] mode, req_t rq);
        logic [IN_TDATA_W-1:0] word;
        int                    pause;
        word = '0;
        word[REQ_W-1:0] = rq;
        s_axis_tdata  <= word;
        s_axis_tuser  <= mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        pause = draw_gap();
        if (pause > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    task automatic send_fields(logic [2:0] mode, logic [31:0] kid, logic [31:0] ep,
                               logic [31:0] rid, logic [31:0] rep, logic [3:0] roles,
                               logic [63:0] nb, logic [63:0] na, logic [1:0] life,
                               logic kmo);
        req_t rq;
        rq.key_id          = kid;
        rq.epoch           = ep;
        rq.rec_key_id      = rid;
        rq.rec_epoch       = rep;
        rq.role_mask       = roles;
        rq.valid_from      = nb;
        rq.valid_until     = na;
        rq.rec_lifecycle   = life;
        rq.key_material_ok = kmo;
        send_item(mode, rq);
    endtask

    // stop sending and wait for every awaited result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(logic [3:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic make_random_item(output logic [2:0] mode, output req_t rq);
        int unsigned pick;
        int unsigned lp;
        logic [63:0] span;
        pick = $urandom_range(0, 99);
        mode = 3'($urandom_range(0, 7));
        rq.key_id          = $urandom;
        rq.epoch           = $urandom;
        rq.rec_key_id      = $urandom;
        rq.rec_epoch       = $urandom;
        rq.role_mask       = 4'($urandom);
        rq.valid_from      = {$urandom, $urandom};
        rq.valid_until     = {$urandom, $urandom};
        rq.rec_lifecycle   = 2'($urandom);
        rq.key_material_ok = 1'($urandom);
        if (pick < 8)
            return;
        if ($urandom_range(0, 3) == 0)
            rq.valid_from = '0;
        span = ($urandom_range(0, 19) == 0) ? 64'd0 : 64'($urandom_range(1, 100000));
        rq.valid_until     = rq.valid_from + span;
        rq.role_mask       = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        rq.key_material_ok = ($urandom_range(0, 19) != 0);
        lp = $urandom_range(0, 19);
        if (lp < 14)
            rq.rec_lifecycle = LIFE_ACTIVE;
        else if (lp < 16)
            rq.rec_lifecycle = LIFE_RETIRED;
        else if (lp < 19)
            rq.rec_lifecycle = LIFE_REVOKED;
        else
            rq.rec_lifecycle = LIFE_OTHER;
        rq.key_id = pick_id();
        rq.epoch  = pick_epoch();
        if (pick < 30)
            mode = MODE_FIND;
        else if (pick < 58)
        begin
            mode = MODE_UPSERT;
            rq.rec_key_id = pick_id();
            rq.rec_epoch  = pick_epoch();
        end
        else if (pick < 78)
        begin
            mode = MODE_ROTATE;
            rq.rec_key_id = ($urandom_range(0, 9) == 0) ? pick_id() : rq.key_id;
            rq.rec_epoch  = ($urandom_range(0, 7) == 0) ? pick_epoch() :
                            rq.epoch + $urandom_range(1, 2);
            if ($urandom_range(0, 9) != 0)
                rq.rec_lifecycle = LIFE_ACTIVE;
        end
        else if (pick < 90)
            mode = MODE_RETIRE;
        else
            mode = MODE_REVOKE;
    endtask

    initial
    begin
        int         pause;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            pause = draw_gap();
            if (pause > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin
        logic [3:0]  caps [6] = '{4'd6, 4'd0, 4'd1, 4'd15, 4'd8, 4'd4};
        logic [2:0]  mode;
        req_t        rq;
        logic [63:0] top64;
        top64 = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: everything misses
        send_fields(MODE_FIND, 1, 1, 0, 0, 0, 0, 0, LIFE_ACTIVE, 0);
        send_fields(MODE_RETIRE, 1, 1, 0, 0, 0, 0, 0, LIFE_ACTIVE, 0);
        send_fields(MODE_REVOKE, 1, 1, 0, 0, 0, 0, 0, LIFE_ACTIVE, 0);
        send_fields(MODE_ROTATE, 1, 1, 1, 2, 4'hF, 0, 100, LIFE_ACTIVE, 1);
        // record check failures
        send_fields(MODE_UPSERT, 0, 0, 0, 1, 4'hF, 0, 100, LIFE_ACTIVE, 1);
        send_fields(MODE_UPSERT, 0, 0, 1, 0, 4'hF, 0, 100, LIFE_ACTIVE, 1);
        send_fields(MODE_UPSERT, 0, 0, 1, 1, 4'h0, 0, 100, LIFE_ACTIVE, 1);
        send_fields(MODE_UPSERT, 0, 0, 1, 1, 4'hF, 100, 100, LIFE_ACTIVE, 1);
        send_fields(MODE_UPSERT, 0, 0, 1, 1, 4'hF, 0, 100, LIFE_ACTIVE, 0);
        // appends, a revoked record, lifecycle three, then an overwrite
        send_fields(MODE_UPSERT, 0, 0, 1, 1, 4'hF, 0, top64, LIFE_ACTIVE, 1);
        send_fields(MODE_UPSERT, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h1,
                    top64 - 1, top64, LIFE_ACTIVE, 1);
        send_fields(MODE_UPSERT, 0, 0, 2, 1, 4'h2, 10, 20, LIFE_REVOKED, 1);
        send_fields(MODE_UPSERT, 0, 0, 3, 1, 4'h8, 5, 6, LIFE_OTHER, 1);
        send_fields(MODE_UPSERT, 0, 0, 1, 1, 4'h5, 100, 200, LIFE_ACTIVE, 1);
        send_fields(MODE_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, LIFE_ACTIVE, 0);
        // rotate and its refusals
        send_fields(MODE_ROTATE, 1, 1, 1, 2, 4'h3, 1000, 2000, LIFE_ACTIVE, 1);
        send_fields(MODE_FIND, 1, 1, 0, 0, 0, 0, 0, LIFE_ACTIVE, 0);
        send_fields(MODE_ROTATE, 1, 1, 1, 3, 4'h3, 1000, 2000, LIFE_ACTIVE, 1);
        send_fields(MODE_ROTATE, 3, 1, 3, 2, 4'h3, 1000, 2000, LIFE_ACTIVE, 1);
        send_fields(MODE_ROTATE, 1, 2, 1, 2, 4'h3, 1000, 2000, LIFE_ACTIVE, 1);
        send_fields(MODE_ROTATE, 1, 2, 4, 3, 4'h3, 1000, 2000, LIFE_ACTIVE, 1);
        // retire of a revoked entry fails, revoking twice succeeds twice
        send_fields(MODE_RETIRE, 2, 1, 0, 0, 0, 0, 0, LIFE_ACTIVE, 0);
        send_fields(MODE_REVOKE, 1, 2, 0, 0, 0, 0, 0, LIFE_ACTIVE, 0);
        send_fields(MODE_REVOKE, 1, 2, 0, 0, 0, 0, 0, LIFE_ACTIVE, 0);
        send_fields(MODE_SPARE_LO, 1, 1, 1, 1, 4'hF, 0, 100, LIFE_ACTIVE, 1);
        send_fields(MODE_SPARE_HI, 1, 1, 1, 1, 4'hF, 0, 100, LIFE_ACTIVE, 1);
        drain();

        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                quiet = ((n % 150) >= 120);
                make_random_item(mode, rq);
                send_item(mode, rq);
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
            drain();
        end

        if (fail_count == 0 && awaiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
src/rkrt_pkg.sv
src/rkrt_ram.sv
src/root_key_ring_table.sv
test/rkrt_table_checker.sv
test/root_key_ring_table_tb.sv
